/* src/point_segment_distance_defines.svh */
// Assertion macros used by the checker file of the point-to-segment block.
// Depends on nothing; included by file name where assertions are written.
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define PSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Check that holds in the cycle after reset is applied.
`define PSD_ASSERT_RST(lbl, clk, rstn, cons) \
  lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

/* src/psd_pkg.sv */
// Shared types and constants of the point-to-segment distance block.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package psd_pkg;

  localparam int CW      = 32;          // coordinate width
  localparam int DW      = CW + 1;      // coordinate difference width
  localparam int PW      = 2 * DW;      // product of two differences
  localparam int SQW     = PW;          // squared length, sum of three squares
  localparam int CRW     = PW + 1;      // cross-product component
  localparam int NUMW    = 2 * SQW;     // squared cross-product norm
  localparam int QW      = SQW;         // quotient width
  localparam int ROOTW   = QW / 2;      // root width, also the distance width
  localparam int IN_DW   = 9 * CW;      // input tdata width
  localparam int OUT_DW  = 40;          // output tdata width, whole bytes
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;

  typedef enum logic [1:0] {
    PART_INTERIOR = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2
  } part_t;

  typedef struct packed {
    logic  degen;
    part_t part;
  } meta_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    meta_t                     meta;
    logic                      is_end;   // endpoint case: root of sq directly
    logic [SQW-1:0]            sq;
    logic [SQW-1:0]            dd;
    logic [2:0][CRW-1:0]       cr;
  } item_t;

endpackage

/* src/psd_front.sv */
// Front part: differences, dot and cross products, and classification.
// Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [psd_pkg::IN_DW-1:0]   in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output psd_pkg::item_t              out_item
);

  logic en;
  logic f1_v_r, f2_v_r, f3_v_r, f4_v_r;

  logic signed [psd_pkg::DW-1:0] d_r [3], v_r [3], w_r [3];
  logic signed [psd_pkg::DW-1:0] d_nxt [3], v_nxt [3], w_nxt [3];
  logic signed [psd_pkg::PW-1:0] ddp_r [3], tp_r [3], vvp_r [3], wwp_r [3], xp_r [6];
  logic [psd_pkg::SQW-1:0]       dd_r, vv_r, ww_r;
  logic signed [psd_pkg::SQW:0]  t_r;
  logic [2:0][psd_pkg::CRW-1:0]  cr_r;
  psd_pkg::item_t                item_r, item_nxt;

  assign en       = !f4_v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [psd_pkg::CW-1:0] c [9];
    for (int k = 0; k < 9; k++) begin
      c[k] = in_data[psd_pkg::CW*k +: psd_pkg::CW];
    end
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = $signed({c[6+i][psd_pkg::CW-1], c[6+i]} - {c[3+i][psd_pkg::CW-1], c[3+i]});
      v_nxt[i] = $signed({c[i][psd_pkg::CW-1], c[i]} - {c[3+i][psd_pkg::CW-1], c[3+i]});
      w_nxt[i] = $signed({c[i][psd_pkg::CW-1], c[i]} - {c[6+i][psd_pkg::CW-1], c[6+i]});
    end
    // Planar items drop the z axis entirely.
    if (in_mode) begin
      d_nxt[2] = '0;
      v_nxt[2] = '0;
      w_nxt[2] = '0;
    end
  end

  always_comb begin
    logic start_c, end_c, degen_c;
    degen_c = (dd_r == '0);
    start_c = degen_c || t_r[psd_pkg::SQW] || (t_r == '0);
    end_c   = !start_c && (t_r[psd_pkg::SQW-1:0] >= dd_r);
    item_nxt.meta.degen = degen_c;
    item_nxt.is_end     = start_c || end_c;
    item_nxt.dd         = dd_r;
    item_nxt.cr         = cr_r;
    if (start_c) begin
      item_nxt.meta.part = psd_pkg::PART_START;
      item_nxt.sq        = vv_r;
    end else if (end_c) begin
      item_nxt.meta.part = psd_pkg::PART_END;
      item_nxt.sq        = ww_r;
    end else begin
      item_nxt.meta.part = psd_pkg::PART_INTERIOR;
      item_nxt.sq        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      v_r <= v_nxt;
      w_r <= w_nxt;
      for (int i = 0; i < 3; i++) begin
        ddp_r[i] <= d_r[i] * d_r[i];
        tp_r[i]  <= v_r[i] * d_r[i];
        vvp_r[i] <= v_r[i] * v_r[i];
        wwp_r[i] <= w_r[i] * w_r[i];
      end
      xp_r[0] <= v_r[1] * d_r[2];
      xp_r[1] <= v_r[2] * d_r[1];
      xp_r[2] <= v_r[2] * d_r[0];
      xp_r[3] <= v_r[0] * d_r[2];
      xp_r[4] <= v_r[0] * d_r[1];
      xp_r[5] <= v_r[1] * d_r[0];
      dd_r <= $unsigned(ddp_r[0]) + $unsigned(ddp_r[1]) + $unsigned(ddp_r[2]);
      vv_r <= $unsigned(vvp_r[0]) + $unsigned(vvp_r[1]) + $unsigned(vvp_r[2]);
      ww_r <= $unsigned(wwp_r[0]) + $unsigned(wwp_r[1]) + $unsigned(wwp_r[2]);
      t_r  <= $signed({tp_r[0][psd_pkg::PW-1], tp_r[0]} + {tp_r[1][psd_pkg::PW-1], tp_r[1]}
                      + {tp_r[2][psd_pkg::PW-1], tp_r[2]});
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= {xp_r[2*i][psd_pkg::PW-1], xp_r[2*i]}
                 - {xp_r[2*i+1][psd_pkg::PW-1], xp_r[2*i+1]};
      end
      item_r <= item_nxt;
    end
  end

  assign out_valid = f4_v_r;
  assign out_item  = item_r;

endmodule

/* src/psd_queue.sv */
// Short queue of classified items between the front and back parts.
// Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  psd_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output psd_pkg::item_t  pop_item
);

  psd_pkg::item_t             mem_r [psd_pkg::QDEPTH];
  logic [psd_pkg::QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [psd_pkg::QAW:0]      count_r;
  logic                       push, pop;

  assign push_ready = (count_r != 3'(psd_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

/* src/psd_back.sv */
// Back part: squared cross-product norm, pipelined divide and square root.
// Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  psd_pkg::item_t              in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [psd_pkg::ROOTW-1:0]   out_dist,
  output psd_pkg::meta_t              out_meta
);

  localparam int SQW  = psd_pkg::SQW;
  localparam int QW   = psd_pkg::QW;
  localparam int RW   = psd_pkg::ROOTW;
  localparam int HW   = SQW / 2;
  localparam int REMW = RW + 2;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Squaring of the cross-product components.
  logic                 b1_v_r, b2_v_r, b3_v_r;
  psd_pkg::item_t       b1_it_r, b2_it_r, b3_it_r;
  logic [SQW-1:0]       abs_r [3];
  logic [SQW-1:0]       hh_r [3], hl_r [3], ll_r [3];
  logic [2*SQW-1:0]     csq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= in_valid;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_it_r <= in_item;
      b2_it_r <= b1_it_r;
      b3_it_r <= b2_it_r;
      for (int i = 0; i < 3; i++) begin
        abs_r[i] <= in_item.cr[i][SQW] ? SQW'(~in_item.cr[i] + 1'b1) : in_item.cr[i][SQW-1:0];
        hh_r[i]  <= abs_r[i][SQW-1:HW] * abs_r[i][SQW-1:HW];
        hl_r[i]  <= abs_r[i][SQW-1:HW] * abs_r[i][HW-1:0];
        ll_r[i]  <= abs_r[i][HW-1:0] * abs_r[i][HW-1:0];
        csq_r[i] <= {hh_r[i], {SQW{1'b0}}} + {{(HW-1){1'b0}}, hl_r[i], {(HW+1){1'b0}}}
                  + {{SQW{1'b0}}, ll_r[i]};
      end
    end
  end

  // Restoring divide, one quotient bit per stage.
  logic                 dv_v_r   [QW+1];
  psd_pkg::meta_t       dv_meta_r [QW+1];
  logic [QW-1:0]        dv_rem_r [QW+1];
  logic [QW-1:0]        dv_lo_r  [QW+1];
  logic [QW-1:0]        dv_den_r [QW+1];
  logic [QW-1:0]        dv_quo_r [QW+1];
  logic [2*SQW-1:0]     num_nxt;

  always_comb begin
    if (b3_it_r.is_end) num_nxt = {{SQW{1'b0}}, b3_it_r.sq};
    else                num_nxt = csq_r[0] + csq_r[1] + csq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= b3_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_meta_r[0] <= b3_it_r.meta;
      dv_rem_r[0]  <= num_nxt[2*SQW-1:QW];
      dv_lo_r[0]   <= num_nxt[QW-1:0];
      dv_den_r[0]  <= b3_it_r.is_end ? QW'(1) : b3_it_r.dd;
      dv_quo_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [QW:0] sh;
    logic        ge;
    assign sh = {dv_rem_r[k], dv_lo_r[k][QW-1-k]};
    assign ge = (sh >= {1'b0, dv_den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n)  dv_v_r[k+1] <= 1'b0;
      else if (en) dv_v_r[k+1] <= dv_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_meta_r[k+1] <= dv_meta_r[k];
        dv_rem_r[k+1]  <= ge ? QW'(sh - {1'b0, dv_den_r[k]}) : sh[QW-1:0];
        dv_lo_r[k+1]   <= dv_lo_r[k];
        dv_den_r[k+1]  <= dv_den_r[k];
        dv_quo_r[k+1]  <= {dv_quo_r[k][QW-2:0], ge};
      end
    end
  end

  // Digit-by-digit square root, one root bit per stage.
  logic                 sr_v_r    [RW];
  psd_pkg::meta_t       sr_meta_r [RW];
  logic [QW-1:0]        sr_rad_r  [RW];
  logic [REMW:0]        sr_rem_r  [RW];
  logic [RW-1:0]        sr_root_r [RW];

  for (genvar j = 0; j < RW; j++) begin : g_root
    logic                 src_v;
    psd_pkg::meta_t       src_meta;
    logic [QW-1:0]        src_rad;
    logic [REMW:0]        src_rem;
    logic [RW-1:0]        src_root;
    logic [REMW+2:0]      rem_sh;
    logic [REMW+2:0]      sub;
    logic                 ge;

    if (j == 0) begin : g_first
      assign src_v    = dv_v_r[QW];
      assign src_meta = dv_meta_r[QW];
      assign src_rad  = dv_quo_r[QW];
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_next
      assign src_v    = sr_v_r[j-1];
      assign src_meta = sr_meta_r[j-1];
      assign src_rad  = sr_rad_r[j-1];
      assign src_rem  = sr_rem_r[j-1];
      assign src_root = sr_root_r[j-1];
    end

    assign rem_sh = {src_rem, src_rad[QW-1-2*j -: 2]};
    assign sub    = {3'b000, src_root, 2'b01};
    assign ge     = (rem_sh >= sub);

    always_ff @(posedge clk) begin
      if (!rst_n)  sr_v_r[j] <= 1'b0;
      else if (en) sr_v_r[j] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_meta_r[j] <= src_meta;
        sr_rad_r[j]  <= src_rad;
        sr_rem_r[j]  <= ge ? (REMW+1)'(rem_sh - sub) : rem_sh[REMW:0];
        sr_root_r[j] <= {src_root[RW-2:0], ge};
      end
    end
  end

  // Output register.
  logic                 out_v_r;
  logic [RW-1:0]        dist_r;
  psd_pkg::meta_t       meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  out_v_r <= 1'b0;
    else if (en) out_v_r <= sr_v_r[RW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= sr_root_r[RW-1];
      meta_r <= sr_meta_r[RW-1];
    end
  end

  assign out_valid = out_v_r;
  assign out_dist  = dist_r;
  assign out_meta  = meta_r;

endmodule

/* src/point_segment_distance.sv */
// Top level of the point-to-segment distance block: front, queue and back.
// Depends on psd_pkg, psd_front, psd_queue and psd_back.
//
//  channel | direction | tdata                        | tuser
//  in_     | slave     | 9 x 32-bit coordinates       | mode
//  out_    | master    | 33-bit distance, zero padded | degenerate, nearest_part
//
// One item is accepted per cycle while in_tready is high. Each item goes through
// the front part, the queue, a 66-stage divider and a 33-stage square root.
// Reset is synchronous and active low; it empties every stage and the queue.
// A stalled output holds the back part; the four-entry queue then fills before
// the front part and in_tready drop.
`timescale 1ns / 1ps

module point_segment_distance (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pt_x, pt_y, pt_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [psd_pkg::IN_DW-1:0]   in_tdata,
  // mode
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // distance, then seven zero bits
  output logic [psd_pkg::OUT_DW-1:0]  out_tdata,
  // degenerate, nearest_part[1:0]
  output logic [2:0]                  out_tuser
);

  logic                         q_push_valid, q_push_ready;
  logic                         q_pop_valid, q_pop_ready;
  psd_pkg::item_t               q_push_item, q_pop_item;
  logic [psd_pkg::ROOTW-1:0]    distance;
  psd_pkg::meta_t               meta;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .out_valid (q_push_valid),
    .out_ready (q_push_ready),
    .out_item  (q_push_item)
  );

  psd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  psd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_pop_valid),
    .in_ready  (q_pop_ready),
    .in_item   (q_pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dist  (distance),
    .out_meta  (meta)
  );

  assign out_tdata = {{(psd_pkg::OUT_DW - psd_pkg::ROOTW){1'b0}}, distance};
  assign out_tuser = {meta.part, meta.degen};

endmodule

/* src/psd_checker.sv */
// Port-level checks of the point-to-segment distance block, bound to the top.
// Depends on psd_pkg and point_segment_distance_defines.svh.
`timescale 1ns / 1ps
`include "point_segment_distance_defines.svh"

module psd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [psd_pkg::OUT_DW-1:0]  out_tdata,
  input logic [2:0]                  out_tuser
);

  // A stalled result keeps its valid and its value.
  `PSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // A degenerate segment always reports its first end as nearest.
  `PSD_ASSERT_IMP(a_degen_start, clk, rst_n, out_tvalid && out_tuser[0], out_tuser[2:1] == psd_pkg::PART_START)
  // The nearest-part code never takes its unused value.
  `PSD_ASSERT_IMP(a_part_code, clk, rst_n, out_tvalid, out_tuser[2:1] != 2'd3)
  // The distance never reaches the padding bits.
  `PSD_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[psd_pkg::OUT_DW-1:psd_pkg::ROOTW] == '0)
  // Reset empties the pipeline.
  `PSD_ASSERT_RST(a_reset_empty, clk, rst_n, !out_tvalid)

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/tb_point_segment_distance.sv */
// Self-checking bench for point_segment_distance: random and directed segment queries.
// Depends on psd_pkg and the block's RTL; predicts each distance with wide integer maths.
`timescale 1ns / 1ps

module tb_point_segment_distance;

  typedef struct {
    bit        planar;
    bit [31:0] p[3];
    bit [31:0] s[3];
    bit [31:0] e[3];
  } query_t;

  typedef struct {
    logic [32:0]     distance;
    logic            degen;
    psd_pkg::part_t  part;
  } answer_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [psd_pkg::IN_DW-1:0]    in_tdata;
  logic                         in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [psd_pkg::OUT_DW-1:0]   out_tdata;
  logic [2:0]                   out_tuser;

  int  mismatches = 0;
  bit  hold_output = 0;

  point_segment_distance DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Largest r with r*r*den <= num.
  function automatic logic signed [255:0] floor_root_ratio(logic signed [255:0] num,
                                                             logic signed [255:0] den);
    logic signed [255:0] r;
    logic signed [255:0] c;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (256'sd1 <<< b);
      if (c * c * den <= num) r = c;
    end
    return r;
  endfunction

  function automatic answer_t nearest_distance(query_t q);
    logic signed [255:0] d[3], v[3], w[3], cr[3];
    logic signed [255:0] dd, t, r, one;
    answer_t a;
    one = 1;
    for (int i = 0; i < 3; i++) begin
      if (i == 2 && q.planar) begin
        d[i] = 0; v[i] = 0; w[i] = 0;
      end else begin
        d[i] = $signed(q.e[i]) - $signed(q.s[i]);
        v[i] = $signed(q.p[i]) - $signed(q.s[i]);
        w[i] = $signed(q.p[i]) - $signed(q.e[i]);
      end
    end
    dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    t  = v[0]*d[0] + v[1]*d[1] + v[2]*d[2];
    a.degen = 0;
    if (dd == 0) begin
      a.degen = 1;
      a.part = psd_pkg::PART_START;
      r = floor_root_ratio(v[0]*v[0] + v[1]*v[1] + v[2]*v[2], one);
    end else if (t <= 0) begin
      a.part = psd_pkg::PART_START;
      r = floor_root_ratio(v[0]*v[0] + v[1]*v[1] + v[2]*v[2], one);
    end else if (t >= dd) begin
      a.part = psd_pkg::PART_END;
      r = floor_root_ratio(w[0]*w[0] + w[1]*w[1] + w[2]*w[2], one);
    end else begin
      a.part = psd_pkg::PART_INTERIOR;
      cr[0] = v[1]*d[2] - v[2]*d[1];
      cr[1] = v[2]*d[0] - v[0]*d[2];
      cr[2] = v[0]*d[1] - v[1]*d[0];
      r = floor_root_ratio(cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2], dd);
    end
    if (r > 256'sh1_FFFF_FFFF) r = 256'sh1_FFFF_FFFF;
    a.distance = r[32:0];
    return a;
  endfunction

  class distance_scoreboard;
    answer_t awaited[$];

    function void note_query(query_t q);
      awaited.push_back(nearest_distance(q));
    endfunction

    task check_answer(logic [32:0] distance, logic degen, logic [1:0] part);
      answer_t a;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        a = awaited.pop_front();
        if (distance !== a.distance) report_mismatch("distance", distance, a.distance);
        if (degen !== a.degen) report_mismatch("degenerate", degen, a.degen);
        if (part !== a.part) report_mismatch("nearest_part", part, a.part);
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  distance_scoreboard board = new();

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      board.check_answer(out_tdata[32:0], out_tuser[0], out_tuser[2:1]);

  // Output side: random back-pressure, plus one long hold-off when asked.
  initial begin
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_output) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_output = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_query(query_t q, bit no_gap);
    int gap;
    logic [psd_pkg::IN_DW-1:0] data;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    data = '0;
    for (int i = 0; i < 3; i++) begin
      data[32*i +: 32]       = q.p[i];
      data[96 + 32*i +: 32]  = q.s[i];
      data[192 + 32*i +: 32] = q.e[i];
    end
    in_tvalid <= 1;
    in_tuser  <= q.planar;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    board.note_query(q);
  endtask

  function automatic query_t make_query(bit planar, int px, int py, int pz, int sx, int sy,
                                        int sz, int ex, int ey, int ez);
    query_t q;
    q.planar = planar;
    q.p[0] = px; q.p[1] = py; q.p[2] = pz;
    q.s[0] = sx; q.s[1] = sy; q.s[2] = sz;
    q.e[0] = ex; q.e[1] = ey; q.e[2] = ez;
    return q;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind;
    bit [31:0] span;
    q.planar = $urandom_range(0, 1);
    kind = $urandom_range(0, 9);
    // Mostly small coordinates so that interior projections are common.
    span = (kind < 3) ? 32'hFFFF_FFFF : (kind < 7) ? 32'h0003_FFFF : 32'h0000_00FF;
    for (int i = 0; i < 3; i++) begin
      q.p[i] = $urandom() & span;
      q.s[i] = $urandom() & span;
      q.e[i] = $urandom() & span;
      if (span != 32'hFFFF_FFFF && $urandom_range(0, 1)) begin
        q.p[i] = -q.p[i]; q.s[i] = -q.s[i]; q.e[i] = -q.e[i];
      end
    end
    if (kind == 8) begin
      q.e[0] = q.s[0]; q.e[1] = q.s[1];
      if (!q.planar) q.e[2] = q.s[2];
    end else if (kind == 9) begin
      // Point built from end coordinates, axis by axis; often an end itself.
      for (int i = 0; i < 3; i++)
        q.p[i] = $urandom_range(0, 1) ? q.s[i] : q.e[i];
    end
    return q;
  endfunction

  localparam int MAXP = 32'h7FFF_FFFF;
  localparam int MINN = 32'h8000_0000;

  initial begin
    query_t q;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, degenerate segments, both end regions and the interior.
    send_query(make_query(0, MAXP, MAXP, MAXP, MINN, MINN, MINN, MINN, MINN, MINN), 0);
    send_query(make_query(0, MINN, MINN, MINN, MAXP, MAXP, MAXP, MINN, MINN, MINN), 0);
    send_query(make_query(0, MINN, MAXP, MINN, MAXP, MINN, MAXP, MAXP, MINN, MAXP), 0);
    send_query(make_query(0, MAXP, MINN, MAXP, MINN, MAXP, MINN, MAXP, MINN, MINN), 0);
    send_query(make_query(1, MAXP, MAXP, MINN, MINN, MINN, MAXP, MINN, MAXP, MINN), 0);
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_query(make_query(0, 5, -7, 9, 3, 3, 3, 3, 3, 3), 0);
    send_query(make_query(1, 5, -7, 9, 3, 3, 100, 3, 3, -100), 0);
    send_query(make_query(1, 65536, 65536, 12, -5, 8, 0, 900, -4, 77), 0);
    send_query(make_query(0, -65536, 0, 0, 0, 0, 0, 65536, 0, 0), 0);
    send_query(make_query(0, 0, 65536, 0, 0, 0, 0, 65536, 0, 0), 0);
    send_query(make_query(0, 65536, 65536, 0, 0, 0, 0, 65536, 0, 0), 0);
    send_query(make_query(0, 131072, 3, 0, 0, 0, 0, 65536, 0, 0), 0);
    send_query(make_query(0, 32768, 65536, 65536, 0, 0, 0, 65536, 0, 0), 0);
    send_query(make_query(1, 32768, 65536, 999999, 0, 0, 5, 65536, 0, -5), 0);
    send_query(make_query(0, 1, 1, 1, 0, 0, 0, 3, 3, 3), 0);
    send_query(make_query(0, 0, 0, MAXP, 0, 0, MINN, 0, 0, MAXP), 0);
    send_query(make_query(0, MAXP, 0, 0, MINN, 0, 0, MAXP, 1, 0), 0);

    // Pause until the pipeline drains.
    in_tvalid <= 0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);

    for (int n = 0; n < 450; n++) begin
      if (n == 100) hold_output = 1;
      if (n == 250) begin
        in_tvalid <= 0;
        while (board.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      q = random_query();
      // Back to back across the long hold-off so that the block fills and stalls.
      send_query(q, n >= 100 && n < 250);
    end
    in_tvalid <= 0;

    while (board.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
